### rtl/b2da_pkg.sv
package b2da_pkg;

  // Field widths
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned OUT_DATA_W = 8;

  // Decimal digits needed for the widest unsigned value
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  // ASCII codes, cut to the output field width
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

  // Converter sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } b2da_state_t;

endpackage

### rtl/binary_to_decimal_ascii_unit.sv
// Binary to decimal ASCII converter. Each input transfer carries a 64-bit
// value on in_tdata and a signed flag on in_tuser; the block sends the decimal
// text as one ASCII character per output transfer, most significant digit
// first, with a leading '-' for negative signed values and tlast on the final
// character. Zero gives the single character '0'. The most negative signed
// value gives "-9223372036854775808". One number is handled at a time: the
// binary magnitude is shifted one bit per cycle through a shift-and-add-3
// BCD register, leading zero digits are then dropped one per cycle (up to
// 19 of them), and characters leave one per cycle while the output is taken.
// Dropped zeros and sent digits always add up to 20 digits. The next input
// transfer is taken only after the last character has been offered, and
// output stalls delay it. Most of the time per number goes to the 64-step
// bit-serial conversion loop.
module binary_to_decimal_ascii_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: value[63:0]
  input  logic [b2da_pkg::VALUE_W-1:0]    in_tdata,
  // in_tuser: is_signed[0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: ascii_char[5:0], zeros above
  output logic [b2da_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready
);
  import b2da_pkg::*;

  b2da_state_t            state_r, state_nxt;
  logic [VALUE_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_tlast_r, out_tlast_nxt;
  logic                   slot_free;
  logic                   in_neg;
  logic [3:0]             top_digit;

  // Add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign slot_free = !out_tvalid_r || out_tready;
  assign in_neg    = in_tuser && in_tdata[VALUE_W-1];

  // Sequencer: next state, datapath and output slot
  always_comb begin
    state_nxt      = state_r;
    bin_nxt        = bin_r;
    bcd_nxt        = bcd_r;
    bit_cnt_nxt    = bit_cnt_r;
    dig_cnt_nxt    = dig_cnt_r;
    neg_nxt        = neg_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_char_nxt   = out_char_r;
    out_tlast_nxt  = out_tlast_r;
    in_tready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          neg_nxt     = in_neg;
          bin_nxt     = in_neg ? (VALUE_W'(0) - in_tdata) : in_tdata;
          bcd_nxt     = '0;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_W - 1);
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt     = {bin_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == '0) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits, keep at least one
        if (top_digit == 4'd0 && dig_cnt_r > DIG_CNT_W'(1)) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_char_nxt   = CHAR_MINUS;
          out_tlast_nxt  = 1'b0;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_char_nxt   = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
          out_tlast_nxt  = (dig_cnt_r == DIG_CNT_W'(1));
          bcd_nxt        = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt    = dig_cnt_r - DIG_CNT_W'(1);
          if (dig_cnt_r == DIG_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    dig_cnt_r   <= dig_cnt_nxt;
    neg_r       <= neg_nxt;
    out_char_r  <= out_char_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_tlast_r;

endmodule
